// File: sv/lbsa_pkg.sv
package lbsa_pkg;

    // Default sizes
    localparam int MAX_NODES_DEF   = 1024;
    localparam int MAX_BLOCKS_DEF  = 16;
    localparam int WEIGHT_BITS_DEF = 16;

    // Fixed field widths
    localparam int KIND_W   = 2;
    localparam int NODE_IN_W = 10;
    localparam int LABEL_W  = 4;
    localparam int EDGE_W   = 16;
    localparam int SUM_W    = 40;
    localparam int PAIR_W   = 21;
    localparam int DIFF_W   = 41;
    localparam int NB_W     = 5;

    // Configuration port
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 5;

    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;

    localparam t_cfg_idx REG_NUM_BLOCKS = 1'd0;
    localparam t_cfg_idx REG_HALVE_DIAG = 1'd1;

    localparam logic [NB_W-1:0] NUM_BLOCKS_RST = 5'd16;
    localparam logic            HALVE_DIAG_RST = 1'b1;

    // Item kinds
    typedef logic [KIND_W-1:0] t_kind;

    localparam t_kind KIND_LABEL = 2'd0;
    localparam t_kind KIND_EDGE  = 2'd1;
    localparam t_kind KIND_QUERY = 2'd2;
    localparam t_kind KIND_CLEAR = 2'd3;

    // Shared arithmetic unit operations
    typedef logic [1:0] t_alu_op;

    localparam t_alu_op OP_ADD_SAT = 2'd0;
    localparam t_alu_op OP_SUB     = 2'd1;
    localparam t_alu_op OP_DEC_SAT = 2'd2;
    localparam t_alu_op OP_MUL     = 2'd3;

endpackage

// File: sv/label_block_sum_accumulator.sv
// Channel   Direction  Handshake                  Payload
// cfg       in         i_cfg_valid / o_cfg_ready  i_cfg_index, i_cfg_data
// in        in         i_in_valid / o_in_stall    i_kind .. i_block_col
// out       out        o_out_valid / i_out_stall  o_block_sum .. o_query_error
//
// Items are handled one at a time, o_in_stall high until each is done; a query also
// waits while the result register is stalled, and a clear wipes the tables. A
// single-port node table, a single-port block sum table and one shared arithmetic unit
// serialise the work. After reset a clearing pass runs with o_in_stall high;
// configuration writes are taken throughout. A finished query waits in the output
// register; new items are taken meanwhile.
module label_block_sum_accumulator #(
    parameter int MAX_NODES   = lbsa_pkg::MAX_NODES_DEF,
    parameter int MAX_BLOCKS  = lbsa_pkg::MAX_BLOCKS_DEF,
    parameter int WEIGHT_BITS = lbsa_pkg::WEIGHT_BITS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,

    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [lbsa_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [lbsa_pkg::CFG_DATA_W-1:0]     i_cfg_data,

    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic [lbsa_pkg::KIND_W-1:0]         i_kind,
    input  logic [lbsa_pkg::NODE_IN_W-1:0]      i_node_index,
    input  logic [lbsa_pkg::LABEL_W-1:0]        i_label,
    input  logic [lbsa_pkg::NODE_IN_W-1:0]      i_row_node,
    input  logic [lbsa_pkg::NODE_IN_W-1:0]      i_col_node,
    input  logic [lbsa_pkg::EDGE_W-1:0]         i_edge_weight,
    input  logic [lbsa_pkg::LABEL_W-1:0]        i_block_row,
    input  logic [lbsa_pkg::LABEL_W-1:0]        i_block_col,

    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic [lbsa_pkg::SUM_W-1:0]          o_block_sum,
    output logic [lbsa_pkg::PAIR_W-1:0]         o_pair_count,
    output logic signed [lbsa_pkg::DIFF_W-1:0]  o_non_edge_sum,
    output logic                                o_query_error
);

    localparam int NODE_W    = $clog2(MAX_NODES);
    localparam int BLK_W     = $clog2(MAX_BLOCKS);
    localparam int SIDX_W    = 2 * BLK_W;
    localparam int SUM_DEPTH = 2 ** SIDX_W;
    localparam int CNT_W     = $clog2(MAX_NODES + 1);
    localparam int PROD_W    = 2 * CNT_W;
    localparam int CLR_N     = (MAX_NODES > SUM_DEPTH) ? MAX_NODES : SUM_DEPTH;
    localparam int CLR_W     = $clog2(CLR_N);
    localparam int SUM_W     = lbsa_pkg::SUM_W;
    localparam int DIFF_W    = lbsa_pkg::DIFF_W;
    localparam int PAIR_W    = lbsa_pkg::PAIR_W;

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_CLEAR  = 4'd1;
    localparam logic [3:0] S_L_RD   = 4'd2;
    localparam logic [3:0] S_L_INC  = 4'd3;
    localparam logic [3:0] S_E_RD1  = 4'd4;
    localparam logic [3:0] S_E_RD2  = 4'd5;
    localparam logic [3:0] S_E_ADD  = 4'd6;
    localparam logic [3:0] S_Q_A    = 4'd7;
    localparam logic [3:0] S_Q_MUL  = 4'd8;
    localparam logic [3:0] S_Q_DIAG = 4'd9;
    localparam logic [3:0] S_Q_OUT  = 4'd10;

    // Memories: node entry is {labelled, label}
    logic [BLK_W:0]   node_mem [MAX_NODES];
    logic [SUM_W-1:0] sum_mem  [SUM_DEPTH];

    logic [CNT_W-1:0] r_cnt [MAX_BLOCKS];

    logic [3:0]              r_state, n_state;
    logic [CLR_W-1:0]        r_clr, n_clr;
    logic [lbsa_pkg::NB_W-1:0] r_num_blocks;
    logic                    r_halve;

    logic [NODE_W-1:0]       r_node, n_node;
    logic [NODE_W-1:0]       r_col, n_col;
    logic [BLK_W-1:0]        r_lab, n_lab;
    logic [BLK_W-1:0]        r_lr, n_lr;
    logic [BLK_W-1:0]        r_br, n_br;
    logic [BLK_W-1:0]        r_bc, n_bc;
    logic [SIDX_W-1:0]       r_sidx, n_sidx;
    logic [WEIGHT_BITS-1:0]  r_w, n_w;
    logic                    r_qerr, n_qerr;
    logic                    r_diag, n_diag;
    logic [CNT_W-1:0]        r_ca, n_ca;
    logic [PROD_W-1:0]       r_prod, n_prod;

    logic [BLK_W:0]          r_node_q;
    logic [SUM_W-1:0]        r_sum_q;

    logic                    r_out_vld, n_out_vld;
    logic [SUM_W-1:0]        r_blk_sum, n_blk_sum;
    logic [PAIR_W-1:0]       r_pair, n_pair;
    logic [DIFF_W-1:0]       r_diff, n_diff;
    logic                    r_err_o, n_err_o;

    logic                    node_we, node_re;
    logic [NODE_W-1:0]       node_waddr, node_raddr;
    logic [BLK_W:0]          node_wdata;
    logic                    sum_we, sum_re;
    logic [SIDX_W-1:0]       sum_waddr, sum_raddr;
    logic [SUM_W-1:0]        sum_wdata;
    logic                    cnt_we, cnt_clr;
    logic [BLK_W-1:0]        cnt_idx;
    logic [CNT_W-1:0]        cnt_rd, cnt_wdata;

    lbsa_pkg::t_alu_op       alu_op;
    logic [DIFF_W-1:0]       alu_a, alu_b, alu_y;

    logic                    node_ok, lab_ok, row_ok, col_ok, br_ok, bc_ok;
    logic [SUM_W-1:0]        sum_h;
    logic [PROD_W-1:0]       prod_h;
    logic [PAIR_W-1:0]       pair_v;

    lbsa_alu #(
        .CNT_W (CNT_W)
    ) u_alu (
        .i_op (alu_op),
        .i_a  (alu_a),
        .i_b  (alu_b),
        .o_y  (alu_y)
    );

    assign o_cfg_ready    = 1'b1;
    assign o_in_stall     = (r_state != S_IDLE);
    assign o_out_valid    = r_out_vld;
    assign o_block_sum    = r_blk_sum;
    assign o_pair_count   = r_pair;
    assign o_non_edge_sum = r_diff;
    assign o_query_error  = r_err_o;

    assign node_ok = 32'(i_node_index) < 32'(MAX_NODES);
    assign row_ok  = 32'(i_row_node) < 32'(MAX_NODES);
    assign col_ok  = 32'(i_col_node) < 32'(MAX_NODES);
    assign lab_ok  = (32'(i_label) < 32'(MAX_BLOCKS)) && ({1'b0, i_label} < r_num_blocks);
    assign br_ok   = (32'(i_block_row) < 32'(MAX_BLOCKS))
                     && ({1'b0, i_block_row} < r_num_blocks);
    assign bc_ok   = (32'(i_block_col) < 32'(MAX_BLOCKS))
                     && ({1'b0, i_block_col} < r_num_blocks);

    // Count table read select follows the sequencer step
    always_comb begin
        unique case (r_state)
            S_L_RD:  cnt_idx = r_node_q[BLK_W-1:0];
            S_L_INC: cnt_idx = r_lab;
            S_Q_A:   cnt_idx = r_br;
            S_Q_MUL: cnt_idx = r_bc;
            default: cnt_idx = '0;
        endcase
    end

    assign cnt_rd = r_cnt[cnt_idx];

    // Diagonal halving of the query results
    assign sum_h  = (r_diag && r_halve) ? (r_sum_q >> 1) : r_sum_q;
    assign prod_h = (r_diag && r_halve) ? (r_prod >> 1) : r_prod;
    assign pair_v = PAIR_W'(prod_h);

    always_comb begin
        n_state    = r_state;
        n_clr      = r_clr;
        n_node     = r_node;
        n_col      = r_col;
        n_lab      = r_lab;
        n_lr       = r_lr;
        n_br       = r_br;
        n_bc       = r_bc;
        n_sidx     = r_sidx;
        n_w        = r_w;
        n_qerr     = r_qerr;
        n_diag     = r_diag;
        n_ca       = r_ca;
        n_prod     = r_prod;
        n_out_vld  = r_out_vld && i_out_stall;
        n_blk_sum  = r_blk_sum;
        n_pair     = r_pair;
        n_diff     = r_diff;
        n_err_o    = r_err_o;
        node_we    = 1'b0;
        node_waddr = '0;
        node_wdata = '0;
        node_re    = 1'b0;
        node_raddr = '0;
        sum_we     = 1'b0;
        sum_waddr  = '0;
        sum_wdata  = '0;
        sum_re     = 1'b0;
        sum_raddr  = '0;
        cnt_we     = 1'b0;
        cnt_clr    = 1'b0;
        cnt_wdata  = '0;
        alu_op     = lbsa_pkg::OP_ADD_SAT;
        alu_a      = '0;
        alu_b      = '0;

        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    unique case (i_kind)
                        lbsa_pkg::KIND_LABEL: begin
                            if (node_ok && lab_ok) begin
                                node_re    = 1'b1;
                                node_raddr = NODE_W'(i_node_index);
                                n_node     = NODE_W'(i_node_index);
                                n_lab      = BLK_W'(i_label);
                                n_state    = S_L_RD;
                            end
                        end
                        lbsa_pkg::KIND_EDGE: begin
                            if (row_ok && col_ok) begin
                                node_re    = 1'b1;
                                node_raddr = NODE_W'(i_row_node);
                                n_col      = NODE_W'(i_col_node);
                                n_w        = WEIGHT_BITS'(i_edge_weight);
                                n_state    = S_E_RD1;
                            end
                        end
                        lbsa_pkg::KIND_QUERY: begin
                            n_br      = BLK_W'(i_block_row);
                            n_bc      = BLK_W'(i_block_col);
                            n_qerr    = !(br_ok && bc_ok);
                            n_diag    = (i_block_row == i_block_col);
                            sum_re    = 1'b1;
                            sum_raddr = {BLK_W'(i_block_row), BLK_W'(i_block_col)};
                            n_state   = S_Q_A;
                        end
                        lbsa_pkg::KIND_CLEAR: begin
                            cnt_clr = 1'b1;
                            n_clr   = '0;
                            n_state = S_CLEAR;
                        end
                        default: begin
                            n_state = S_IDLE;
                        end
                    endcase
                end
            end

            S_CLEAR: begin
                if (32'(r_clr) < 32'(MAX_NODES)) begin
                    node_we    = 1'b1;
                    node_waddr = NODE_W'(r_clr);
                end
                if (32'(r_clr) < 32'(SUM_DEPTH)) begin
                    sum_we    = 1'b1;
                    sum_waddr = SIDX_W'(r_clr);
                end
                n_clr = r_clr + CLR_W'(1);
                if (32'(r_clr) == 32'(CLR_N - 1)) begin
                    n_state = S_IDLE;
                end
            end

            S_L_RD: begin
                // leave the old block first
                if (r_node_q[BLK_W]) begin
                    alu_op    = lbsa_pkg::OP_DEC_SAT;
                    alu_a     = DIFF_W'(cnt_rd);
                    cnt_we    = 1'b1;
                    cnt_wdata = CNT_W'(alu_y);
                end
                n_state = S_L_INC;
            end

            S_L_INC: begin
                alu_op     = lbsa_pkg::OP_ADD_SAT;
                alu_a      = DIFF_W'(cnt_rd);
                alu_b      = DIFF_W'(1);
                cnt_we     = 1'b1;
                cnt_wdata  = CNT_W'(alu_y);
                node_we    = 1'b1;
                node_waddr = r_node;
                node_wdata = {1'b1, r_lab};
                n_state    = S_IDLE;
            end

            S_E_RD1: begin
                if (r_node_q[BLK_W]) begin
                    n_lr       = r_node_q[BLK_W-1:0];
                    node_re    = 1'b1;
                    node_raddr = r_col;
                    n_state    = S_E_RD2;
                end else begin
                    n_state = S_IDLE;
                end
            end

            S_E_RD2: begin
                if (r_node_q[BLK_W]) begin
                    sum_re    = 1'b1;
                    sum_raddr = {r_lr, r_node_q[BLK_W-1:0]};
                    n_sidx    = {r_lr, r_node_q[BLK_W-1:0]};
                    n_state   = S_E_ADD;
                end else begin
                    n_state = S_IDLE;
                end
            end

            S_E_ADD: begin
                alu_op    = lbsa_pkg::OP_ADD_SAT;
                alu_a     = DIFF_W'(r_sum_q);
                alu_b     = DIFF_W'(r_w);
                sum_we    = 1'b1;
                sum_waddr = r_sidx;
                sum_wdata = SUM_W'(alu_y);
                n_state   = S_IDLE;
            end

            S_Q_A: begin
                n_ca    = cnt_rd;
                n_state = S_Q_MUL;
            end

            S_Q_MUL: begin
                alu_op  = lbsa_pkg::OP_MUL;
                alu_a   = DIFF_W'(r_ca);
                alu_b   = DIFF_W'(cnt_rd);
                n_prod  = PROD_W'(alu_y);
                n_state = S_Q_DIAG;
            end

            S_Q_DIAG: begin
                // drop self pairs on the diagonal
                if (r_diag) begin
                    alu_op = lbsa_pkg::OP_SUB;
                    alu_a  = DIFF_W'(r_prod);
                    alu_b  = DIFF_W'(r_ca);
                    n_prod = PROD_W'(alu_y);
                end
                n_state = S_Q_OUT;
            end

            S_Q_OUT: begin
                alu_op = lbsa_pkg::OP_SUB;
                alu_a  = DIFF_W'(pair_v);
                alu_b  = DIFF_W'(sum_h);
                // hold until the output register frees up
                if (!r_out_vld || !i_out_stall) begin
                    n_out_vld = 1'b1;
                    if (r_qerr) begin
                        n_blk_sum = '0;
                        n_pair    = '0;
                        n_diff    = '0;
                        n_err_o   = 1'b1;
                    end else begin
                        n_blk_sum = sum_h;
                        n_pair    = pair_v;
                        n_diff    = alu_y;
                        n_err_o   = 1'b0;
                    end
                    n_state = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_CLEAR;
            r_clr        <= '0;
            r_out_vld    <= 1'b0;
            r_num_blocks <= lbsa_pkg::NUM_BLOCKS_RST;
            r_halve      <= lbsa_pkg::HALVE_DIAG_RST;
        end else begin
            r_state   <= n_state;
            r_clr     <= n_clr;
            r_out_vld <= n_out_vld;
            if (i_cfg_valid && o_cfg_ready) begin
                if (i_cfg_index == lbsa_pkg::REG_NUM_BLOCKS) begin
                    r_num_blocks <= i_cfg_data[lbsa_pkg::NB_W-1:0];
                end else if (i_cfg_index == lbsa_pkg::REG_HALVE_DIAG) begin
                    r_halve <= i_cfg_data[0];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || cnt_clr) begin
            for (int i = 0; i < MAX_BLOCKS; i++) begin
                r_cnt[i] <= '0;
            end
        end else if (cnt_we) begin
            r_cnt[cnt_idx] <= cnt_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_node    <= n_node;
        r_col     <= n_col;
        r_lab     <= n_lab;
        r_lr      <= n_lr;
        r_br      <= n_br;
        r_bc      <= n_bc;
        r_sidx    <= n_sidx;
        r_w       <= n_w;
        r_qerr    <= n_qerr;
        r_diag    <= n_diag;
        r_ca      <= n_ca;
        r_prod    <= n_prod;
        r_blk_sum <= n_blk_sum;
        r_pair    <= n_pair;
        r_diff    <= n_diff;
        r_err_o   <= n_err_o;
    end

    always_ff @(posedge i_clk) begin
        if (node_we) begin
            node_mem[node_waddr] <= node_wdata;
        end
        if (node_re) begin
            r_node_q <= node_mem[node_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (sum_we) begin
            sum_mem[sum_waddr] <= sum_wdata;
        end
        if (sum_re) begin
            r_sum_q <= sum_mem[sum_raddr];
        end
    end

endmodule

// File: sv/lbsa_alu.sv
module lbsa_alu #(
    parameter int CNT_W = 11
) (
    input  lbsa_pkg::t_alu_op            i_op,
    input  logic [lbsa_pkg::DIFF_W-1:0]  i_a,
    input  logic [lbsa_pkg::DIFF_W-1:0]  i_b,
    output logic [lbsa_pkg::DIFF_W-1:0]  o_y
);

    localparam int PROD_W = 2 * CNT_W;

    logic [lbsa_pkg::SUM_W:0]   sum;
    logic [PROD_W-1:0]          prod;

    assign sum  = {1'b0, i_a[lbsa_pkg::SUM_W-1:0]} + {1'b0, i_b[lbsa_pkg::SUM_W-1:0]};
    assign prod = PROD_W'(i_a[CNT_W-1:0]) * PROD_W'(i_b[CNT_W-1:0]);

    always_comb begin
        unique case (i_op)
            lbsa_pkg::OP_ADD_SAT: begin
                // clamp at the largest block sum
                if (sum[lbsa_pkg::SUM_W]) begin
                    o_y = {1'b0, {lbsa_pkg::SUM_W{1'b1}}};
                end else begin
                    o_y = lbsa_pkg::DIFF_W'(sum);
                end
            end
            lbsa_pkg::OP_SUB: begin
                o_y = i_a - i_b;
            end
            lbsa_pkg::OP_DEC_SAT: begin
                if (i_a == '0) begin
                    o_y = '0;
                end else begin
                    o_y = i_a - lbsa_pkg::DIFF_W'(1);
                end
            end
            lbsa_pkg::OP_MUL: begin
                o_y = lbsa_pkg::DIFF_W'(prod);
            end
            default: begin
                o_y = '0;
            end
        endcase
    end

endmodule
